>>> hdl/assert_macros.svh
// Assertion macros shared by the copier RTL.
// Every check is clocked on a rising edge and held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

>>> hdl/utf8c_pkg.sv
// Shared types and constants for the UTF-8 validating copier.
// No dependencies; used by the scanner, the output queue and the top level.
`timescale 1ns / 1ps

package utf8c_pkg;

	// Most words one input word can release: four code point bytes plus terminator.
	localparam int unsigned MAX_GROUP = 5;
	localparam int unsigned FIFO_DEPTH_DEF = 8;
	localparam logic [7:0] LIMIT_RESET = 8'd63;

	// Byte classification masks and bounds
	localparam logic [7:0] MSB_MASK   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] LEAD_E0    = 8'hE0;
	localparam logic [7:0] LEAD_ED    = 8'hED;
	localparam logic [7:0] LEAD_F0    = 8'hF0;
	localparam logic [7:0] LEAD_F4    = 8'hF4;
	localparam logic [7:0] E0_MIN     = 8'hA0;
	localparam logic [7:0] ED_LIMIT   = 8'hA0;
	localparam logic [7:0] F0_MIN     = 8'h90;
	localparam logic [7:0] F4_MAX     = 8'h8F;

	// Words released by one input word: payload bytes in order, then an optional terminator
	typedef struct packed {
		logic             valid;
		logic [2:0]       n_payload;
		logic             term;
		logic [3:0][7:0]  bytes;
	} group_t;

endpackage

>>> hdl/utf8c_scanner.sv
// Input register plus the UTF-8 decode/check state; emits at most one word group per input word.
// Depends on utf8c_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8c_scanner (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,
	input  logic                  string_start,
	input  logic [7:0]            copy_limit,
	input  logic                  room,
	output utf8c_pkg::group_t     group
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Decode state
	logic [3:0][7:0] pend_q;
	logic [2:0]      pcount_q;
	logic [2:0]      elen_q;
	logic [7:0]      written_q;
	logic            finished_q;

	logic       consume;
	logic       active;
	logic [2:0] pc;
	logic [2:0] el;
	logic [7:0] bw;
	logic [2:0] len;
	logic [2:0] new_el;
	logic [2:0] new_pc;
	logic [8:0] lead_sum;
	logic [8:0] cont_sum;
	logic       lead_bad;
	logic       cont_bad;
	logic       second_bad;
	logic       bad;
	logic       complete;
	logic [7:0] bw_new;
	logic       term;

	assign in_stall = valid_s1 && !room;
	assign consume  = valid_s1 && room;

	// Input register: takes a word whenever the stage is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= in_byte;
			start_s1 <= string_start;
		end
	end

	// Lead byte length: 0 marks an invalid lead
	always_comb begin
		if ((byte_s1 & utf8c_pkg::MSB_MASK) == 8'h00) begin
			len = 3'd1;
		end else if ((byte_s1 & utf8c_pkg::LEAD2_MASK) == utf8c_pkg::LEAD2_CODE) begin
			len = 3'd2;
		end else if ((byte_s1 & utf8c_pkg::LEAD3_MASK) == utf8c_pkg::LEAD3_CODE) begin
			len = 3'd3;
		end else if ((byte_s1 & utf8c_pkg::LEAD4_MASK) == utf8c_pkg::LEAD4_CODE) begin
			len = 3'd4;
		end else begin
			len = 3'd0;
		end
	end

	// Check and assemble one byte; a string start sees cleared state
	always_comb begin
		pc       = start_s1 ? 3'd0 : pcount_q;
		el       = start_s1 ? 3'd0 : elen_q;
		bw       = start_s1 ? 8'd0 : written_q;
		active   = start_s1 || !finished_q;
		lead_sum = {1'b0, bw} + {6'd0, len};
		cont_sum = {1'b0, bw} + {6'd0, el};

		lead_bad = (bw >= copy_limit) || (byte_s1 == 8'h00) || (len == 3'd0)
			|| (lead_sum > {1'b0, copy_limit})
			|| ((len == 3'd2) && (byte_s1 < utf8c_pkg::LEAD2_MIN))
			|| ((len == 3'd4) && (byte_s1 > utf8c_pkg::LEAD4_MAX));

		// Overlong, surrogate and out-of-range forms show in the second byte
		second_bad = (pc == 3'd1) && (
			((pend_q[0] == utf8c_pkg::LEAD_E0) && (byte_s1 < utf8c_pkg::E0_MIN))
			|| ((pend_q[0] == utf8c_pkg::LEAD_ED) && (byte_s1 >= utf8c_pkg::ED_LIMIT))
			|| ((pend_q[0] == utf8c_pkg::LEAD_F0) && (byte_s1 < utf8c_pkg::F0_MIN))
			|| ((pend_q[0] == utf8c_pkg::LEAD_F4) && (byte_s1 > utf8c_pkg::F4_MAX)));

		cont_bad = (cont_sum > {1'b0, copy_limit})
			|| ((byte_s1 & utf8c_pkg::CONT_MASK) != utf8c_pkg::CONT_CODE)
			|| second_bad || (pc > 3'd3);

		bad      = (el == 3'd0) ? lead_bad : cont_bad;
		new_el   = (el == 3'd0) ? len : el;
		new_pc   = pc + 3'd1;
		complete = !bad && (new_pc >= new_el);
		bw_new   = bw + {5'd0, new_pc};
		term     = bad || (complete && (bw_new >= copy_limit));

		group.valid     = consume && active;
		group.n_payload = complete ? new_pc : 3'd0;
		group.term      = term;
		for (int i = 0; i < 4; i++) begin
			group.bytes[i] = (pc[1:0] == 2'(i)) ? byte_s1 : pend_q[i];
		end
	end

	// Control state update, once per consumed word while the copy is active
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q   <= 3'd0;
			elen_q     <= 3'd0;
			written_q  <= 8'd0;
			finished_q <= 1'b1;
		end else if (consume && active) begin
			finished_q <= term;
			written_q  <= complete ? bw_new : bw;
			if (term || complete) begin
				pcount_q <= 3'd0;
				elen_q   <= 3'd0;
			end else begin
				pcount_q <= new_pc;
				elen_q   <= new_el;
			end
		end
	end

	// Held code point bytes
	always_ff @(posedge clk) begin
		if (consume && active && !bad && !complete) begin
			pend_q[pc[1:0]] <= byte_s1;
		end
	end

	`ASSERT_AT(a_idle_empty, clk, arst_n, (elen_q != 3'd0) || (pcount_q == 3'd0), "bytes held with no sequence open")
	`ASSERT_AT(a_hold_short, clk, arst_n, (elen_q == 3'd0) || (pcount_q < elen_q), "held count reached sequence length")
	`ASSERT_AT(a_term_done, clk, arst_n, (group.valid && group.term) |=> finished_q, "terminator sent but copy not finished")
	`ASSERT_NEVER(a_done_hold, clk, arst_n, finished_q && (elen_q != 3'd0), "finished copy still holds a sequence")

endmodule

>>> hdl/utf8c_out_fifo.sv
// Output word queue: takes a group of up to five words per cycle, sends one per cycle unless out_stall is high.
// Depends on utf8c_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8c_out_fifo #(
	parameter int unsigned DEPTH = utf8c_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  utf8c_pkg::group_t  group,
	output logic               room,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               is_last
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] ROOM_LIM = CW'(DEPTH - utf8c_pkg::MAX_GROUP);
	localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);

	logic [8:0]    mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [2:0]    push_n;
	logic          pop;
	logic [AW:0]   slot_sum [utf8c_pkg::MAX_GROUP];
	logic [AW-1:0] slot [utf8c_pkg::MAX_GROUP];
	logic [AW:0]   wr_sum;
	logic [AW:0]   rd_sum;

	assign room      = (count_q <= ROOM_LIM);
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_byte  = mem_q[rd_q][7:0];
	assign is_last   = mem_q[rd_q][8];
	assign push_n    = group.valid ? (group.n_payload + {2'd0, group.term}) : 3'd0;

	// Write slots, wrapped into the queue
	always_comb begin
		for (int k = 0; k < utf8c_pkg::MAX_GROUP; k++) begin
			slot_sum[k] = {1'b0, wr_q} + (AW + 1)'(k);
			slot[k] = (slot_sum[k] >= DEPTH_W) ? AW'(slot_sum[k] - DEPTH_W) : AW'(slot_sum[k]);
		end
		wr_sum = {1'b0, wr_q} + {{(AW - 2){1'b0}}, push_n};
		rd_sum = {1'b0, rd_q} + (AW + 1)'(1);
	end

	// Payload words first, terminator after them
	always_ff @(posedge clk) begin
		if (group.valid) begin
			for (int k = 0; k < utf8c_pkg::MAX_GROUP; k++) begin
				if (3'(k) < group.n_payload) begin
					mem_q[slot[k]] <= {1'b0, group.bytes[k % 4]};
				end else if ((3'(k) == group.n_payload) && group.term) begin
					mem_q[slot[k]] <= {1'b1, 8'h00};
				end
			end
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= (wr_sum >= DEPTH_W) ? AW'(wr_sum - DEPTH_W) : AW'(wr_sum);
			if (pop) begin
				rd_q <= (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : AW'(rd_sum);
			end
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

	`ASSERT_AT(a_no_overflow, clk, arst_n, group.valid |-> (count_q <= ROOM_LIM), "group pushed without room")
	`ASSERT_AT(a_count_max, clk, arst_n, count_q <= CW'(DEPTH), "queue count beyond depth")
	`ASSERT_AT(a_count_step, clk, arst_n, (!group.valid && !pop) |=> $stable(count_q), "count moved with no push or pop")

endmodule

>>> hdl/utf8_validating_truncating_copier.sv
// UTF-8 validating truncating copier: one source byte per word in, one output byte per word out.
// The first result word passes through the scanner input register and then the output queue.
// Throughput: one input word per cycle while in_stall is low; output drains one word per cycle
// while out_stall is low from an 8-word queue; input stalls while more than three words wait there.
// Reset clears the queue, sets the copy finished (idle until a string starts), limit = 63.
`timescale 1ns / 1ps

module utf8_validating_truncating_copier #(
	parameter int unsigned FIFO_DEPTH = utf8c_pkg::FIFO_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       string_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_last
);

	logic [7:0]        copy_limit_q;
	logic              room;
	utf8c_pkg::group_t group;

	// Copy limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_limit_q <= utf8c_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			copy_limit_q <= cfg_wdata;
		end
	end

	utf8c_scanner u_scanner (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.string_start (string_start),
		.copy_limit   (copy_limit_q),
		.room         (room),
		.group        (group)
	);

	utf8c_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.group     (group),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.is_last   (is_last)
	);

endmodule
